// ===== sv/sasb_pkg.sv =====
// ----------------------------------------------------------------------------
// sasb_pkg
// Types, register indexes and helpers shared by the scaled alpha sprite
// blitter.
// ----------------------------------------------------------------------------
package sasb_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_MAX_SCALE  = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int COORD_W    = 12;
    localparam int MAC_AB_W   = 9;
    localparam int MAC_W      = 18;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_FACTOR  = 3'd4;

    localparam logic [8:0] RST_SCREEN_WIDTH  = 9'd256;
    localparam logic [8:0] RST_SCREEN_HEIGHT = 9'd256;
    localparam logic [3:0] RST_SCALE_FACTOR  = 4'd1;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

    typedef struct packed {
        logic [7:0]  source_col;
        logic [7:0]  source_row;
        logic [31:0] source_argb;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  target_col;
        logic [7:0]  target_row;
        logic [31:0] written_argb;
        logic        final_write;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BASE_X,
        ST_BASE_Y,
        ST_ADDR,
        ST_READ,
        ST_BLEND,
        ST_WRITE
    } state_t;

    // floor(v / 255) for v below 65280
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

// ===== sv/scaled_alpha_sprite_blitter.sv =====
// ----------------------------------------------------------------------------
// scaled_alpha_sprite_blitter
// Draws one ARGB source pixel as a clipped, scaled square into an on-chip
// frame store, blending against stored pixels, and reports every write.
// ----------------------------------------------------------------------------
// After reset the block sweeps all MAX_WIDTH*MAX_HEIGHT words of the frame
// store (65536 at the defaults) to zero, one word a cycle, with busy high. A
// word is taken when start is high and busy low. The setup states BASE_X and
// BASE_Y form the corner of the square through the shared multiply-add unit;
// then each target pixel passes through address and write when opaque, or
// through address, frame read, six multiply-add steps for three channels and
// write when blended. A transparent word, or one taken at scale zero, is
// dropped in the cycle it is taken and busy never rises; a fully clipped
// square returns to idle from its first address state after setup. Each
// written pixel shows on result for one cycle with strobe high, the cycle
// after its write; the receiver cannot stall and needs no handshake back.
// ----------------------------------------------------------------------------
module scaled_alpha_sprite_blitter #(
    parameter int MAX_WIDTH  = sasb_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = sasb_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_SCALE  = sasb_pkg::DEF_MAX_SCALE
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sasb_pkg::in_word_t            src_word,
    input  logic                          cfg_we,
    input  logic [sasb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sasb_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                          strobe,
    output sasb_pkg::out_word_t           result
);
    import sasb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int WCAP  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
    localparam int HCAP  = (MAX_HEIGHT > 511) ? 511 : MAX_HEIGHT;

    logic [31:0] mem [DEPTH];

    state_t state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [8:0] width_reg, height_reg;
    logic [7:0] origin_x_reg, origin_y_reg;
    logic [3:0] scale_reg;

    in_word_t src_reg, src_next;
    logic [COORD_W-1:0] bx_reg, bx_next, x_reg, x_next, y_reg, y_next;
    logic [3:0] i_reg, i_next, j_reg, j_next;
    logic [2:0] k_reg, k_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [MAC_W-1:0] acc_reg, acc_next;
    logic [23:0] rgb_reg, rgb_next;
    logic [31:0] rd_data_reg;
    logic strobe_reg, strobe_next;
    out_word_t result_reg, result_next;

    logic [8:0] w_eff, h_eff;
    logic [3:0] sc_eff;
    logic [7:0] alpha;
    logic [MAC_AB_W-1:0] mac_a, mac_b;
    logic [MAC_W-1:0] mac_c, mac_res;
    logic [7:0] ch_s, ch_d, ch_q;
    logic last_col, last_row;
    logic [31:0] wr_val;
    logic mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0] mem_wdata;

    assign w_eff  = (width_reg > 9'(WCAP)) ? 9'(WCAP) : width_reg;
    assign h_eff  = (height_reg > 9'(HCAP)) ? 9'(HCAP) : height_reg;
    assign sc_eff = (scale_reg > 4'(MAX_SCALE)) ? 4'(MAX_SCALE) : scale_reg;
    assign alpha  = src_reg.source_argb[31:24];

    assign mac_res = 18'(mac_a * mac_b) + mac_c;
    assign ch_q    = div255(mac_res[15:0]);

    assign last_col = (j_reg == sc_eff - 4'd1) || ((x_reg + 12'd1) >= 12'(w_eff));
    assign last_row = (i_reg == sc_eff - 4'd1) || ((y_reg + 12'd1) >= 12'(h_eff));
    assign wr_val   = (alpha == ALPHA_OPAQUE)
                    ? {ALPHA_OPAQUE, src_reg.source_argb[23:0]}
                    : {ALPHA_OPAQUE, rgb_reg};

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    always_comb
    begin
        case (k_reg[2:1])
            2'd0:
            begin
                ch_s = src_reg.source_argb[23:16];
                ch_d = rd_data_reg[23:16];
            end
            2'd1:
            begin
                ch_s = src_reg.source_argb[15:8];
                ch_d = rd_data_reg[15:8];
            end
            default:
            begin
                ch_s = src_reg.source_argb[7:0];
                ch_d = rd_data_reg[7:0];
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        src_next     = src_reg;
        bx_next      = bx_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        addr_next    = addr_reg;
        acc_next     = acc_reg;
        rgb_next     = rgb_reg;
        strobe_next  = 1'b0;
        result_next  = result_reg;
        mac_a        = '0;
        mac_b        = '0;
        mac_c        = '0;
        mem_we       = 1'b0;
        mem_waddr    = addr_reg;
        mem_wdata    = wr_val;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    src_next = src_word;
                    i_next   = '0;
                    j_next   = '0;
                    if (sc_eff != 4'd0 && src_word.source_argb[31:24] != ALPHA_CLEAR)
                    begin
                        state_next = ST_BASE_X;
                    end
                end
            end
            ST_BASE_X:
            begin
                mac_a   = 9'(src_reg.source_col);
                mac_b   = 9'(sc_eff);
                mac_c   = 18'(origin_x_reg);
                bx_next = mac_res[COORD_W-1:0];
                x_next  = mac_res[COORD_W-1:0];
                state_next = ST_BASE_Y;
            end
            ST_BASE_Y:
            begin
                mac_a  = 9'(src_reg.source_row);
                mac_b  = 9'(sc_eff);
                mac_c  = 18'(origin_y_reg);
                y_next = mac_res[COORD_W-1:0];
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                mac_a     = y_reg[8:0];
                mac_b     = w_eff;
                mac_c     = 18'(x_reg[8:0]);
                addr_next = AW'(mac_res);
                k_next    = '0;
                if (y_reg >= 12'(h_eff) || x_reg >= 12'(w_eff))
                begin
                    state_next = ST_IDLE;
                end
                else if (alpha == ALPHA_OPAQUE)
                begin
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_BLEND;
            end
            ST_BLEND:
            begin
                if (!k_reg[0])
                begin
                    mac_a    = 9'(ch_s);
                    mac_b    = 9'(alpha);
                    acc_next = mac_res;
                end
                else
                begin
                    mac_a = 9'(ch_d);
                    mac_b = 9'(8'(ALPHA_OPAQUE - alpha));
                    mac_c = acc_reg;
                    case (k_reg[2:1])
                        2'd0:    rgb_next[23:16] = ch_q;
                        2'd1:    rgb_next[15:8]  = ch_q;
                        default: rgb_next[7:0]   = ch_q;
                    endcase
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd5)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                mem_we = 1'b1;
                strobe_next = 1'b1;
                result_next.target_col   = x_reg[7:0];
                result_next.target_row   = y_reg[7:0];
                result_next.written_argb = wr_val;
                result_next.final_write  = last_col && last_row;
                if (last_col && last_row)
                begin
                    state_next = ST_IDLE;
                end
                else if (last_col)
                begin
                    x_next = bx_reg;
                    j_next = '0;
                    y_next = y_reg + 12'd1;
                    i_next = i_reg + 4'd1;
                    state_next = ST_ADDR;
                end
                else
                begin
                    x_next = x_reg + 12'd1;
                    j_next = j_reg + 4'd1;
                    state_next = ST_ADDR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            strobe_reg   <= 1'b0;
            width_reg    <= RST_SCREEN_WIDTH;
            height_reg   <= RST_SCREEN_HEIGHT;
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= RST_SCALE_FACTOR;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            strobe_reg  <= strobe_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SCREEN_WIDTH:  width_reg    <= cfg_data;
                    REG_SCREEN_HEIGHT: height_reg   <= cfg_data;
                    REG_ORIGIN_X:      origin_x_reg <= cfg_data[7:0];
                    REG_ORIGIN_Y:      origin_y_reg <= cfg_data[7:0];
                    REG_SCALE_FACTOR:  scale_reg    <= cfg_data[3:0];
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg    <= src_next;
        bx_reg     <= bx_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        addr_reg   <= addr_next;
        acc_reg    <= acc_next;
        rgb_reg    <= rgb_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

endmodule
